FILE: sv/cd_pkg.sv
package cd_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;

  // capacity register
  localparam int             CAP_W     = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // register index of capacity in the configuration map
  localparam logic REG_CAPACITY = 1'b0;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_REAR  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_REAR   = 3'd3,
    OP_PEEK_FRONT = 3'd4,
    OP_PEEK_REAR  = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RDWAIT
  } state_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic capture;
  } cd_cmd_t;

  typedef struct packed {
    logic peek_hit;
  } cd_sts_t;

endpackage

FILE: sv/cd_ram.sv
module cd_ram import cd_pkg::*; #(
  parameter int WIDTH = DATA_WIDTH_DEF,
  parameter int DEPTH = DEPTH_DEF,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: sv/cd_ctrl.sv
module cd_ctrl import cd_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    start,
  input  cd_sts_t sts,
  output cd_cmd_t cmd,
  output logic    busy
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    busy        = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec  = 1'b1;
        // a successful peek waits in ST_RDWAIT for the registered ring read
        state_nxt = sts.peek_hit ? ST_RDWAIT : ST_IDLE;
      end
      ST_RDWAIT: begin
        cmd.capture = 1'b1;
        state_nxt   = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: sv/cd_dpath.sv
module cd_dpath import cd_pkg::*; #(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cd_cmd_t           cmd,
  output cd_sts_t           sts,
  input  logic [CAP_W-1:0]  capacity,
  input  logic [2:0]        in_operation,
  input  logic signed [31:0] in_value,
  output logic              out_strobe,
  output logic              out_ok,
  output logic signed [31:0] out_data,
  output logic              out_is_empty,
  output logic              out_is_full
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CMP_W = ((IDX_W > CAP_W) ? IDX_W : CAP_W) + 1;

  op_t                     op_r;
  logic [31:0]             value_r;
  logic [IDX_W-1:0]        front_r, front_nxt;
  logic [IDX_W-1:0]        rear_r, rear_nxt;
  logic                    empty_r, empty_nxt;
  logic                    strobe_r;
  logic                    ok_r;
  logic [31:0]             data_r;
  logic                    is_empty_r;
  logic                    is_full_r;

  logic [CAP_W-1:0]        cap_eff;
  logic                    full_now, full_after;
  logic                    ok;
  logic                    peek_hit;
  logic                    we, re;
  logic [IDX_W-1:0]        waddr, raddr;
  logic [DATA_WIDTH-1:0]   wdata;
  logic [DATA_WIDTH-1:0]   rdata;
  logic signed [DATA_WIDTH-1:0] rdata_s;
  logic signed [63:0]      rdata_ext;

  function automatic logic [IDX_W-1:0] idx_next(input logic [IDX_W-1:0] i,
                                                 input logic [CAP_W-1:0] cap);
    logic [CMP_W-1:0] inc;
    inc = CMP_W'(i) + CMP_W'(1);
    return (inc >= CMP_W'(cap)) ? '0 : IDX_W'(inc);
  endfunction

  function automatic logic [IDX_W-1:0] idx_prev(input logic [IDX_W-1:0] i,
                                                 input logic [CAP_W-1:0] cap);
    logic [CAP_W-1:0] top;
    top = cap - CAP_W'(1);
    if (i == '0 || CMP_W'(i) > CMP_W'(cap)) begin
      return IDX_W'(top);
    end
    return i - IDX_W'(1);
  endfunction

  // clamp capacity to 1..DEPTH
  always_comb begin
    if (capacity == '0) begin
      cap_eff = CAP_W'(1);
    end else if (32'(capacity) > 32'(DEPTH)) begin
      cap_eff = CAP_W'(DEPTH);
    end else begin
      cap_eff = capacity;
    end
  end

  always_comb begin
    full_now  = !empty_r && (idx_next(rear_r, cap_eff) == front_r);
    front_nxt = front_r;
    rear_nxt  = rear_r;
    empty_nxt = empty_r;
    ok        = 1'b0;
    peek_hit  = 1'b0;
    we        = 1'b0;
    re        = 1'b0;
    waddr     = '0;
    raddr     = front_r;
    unique case (op_r) inside
      OP_PUSH_FRONT, OP_PUSH_REAR: begin
        if (!full_now) begin
          ok = 1'b1;
          we = 1'b1;
          if (empty_r) begin
            front_nxt = '0;
            rear_nxt  = '0;
            empty_nxt = 1'b0;
            waddr     = '0;
          end else if (op_r == OP_PUSH_FRONT) begin
            front_nxt = idx_prev(front_r, cap_eff);
            waddr     = front_nxt;
          end else begin
            rear_nxt = idx_next(rear_r, cap_eff);
            waddr    = rear_nxt;
          end
        end
      end
      OP_POP_FRONT, OP_POP_REAR: begin
        if (!empty_r) begin
          ok = 1'b1;
          if (front_r == rear_r) begin
            front_nxt = '0;
            rear_nxt  = '0;
            empty_nxt = 1'b1;
          end else if (op_r == OP_POP_FRONT) begin
            front_nxt = idx_next(front_r, cap_eff);
          end else begin
            rear_nxt = idx_prev(rear_r, cap_eff);
          end
        end
      end
      OP_PEEK_FRONT, OP_PEEK_REAR: begin
        if (!empty_r) begin
          ok       = 1'b1;
          peek_hit = 1'b1;
          re       = 1'b1;
          raddr    = (op_r == OP_PEEK_FRONT) ? front_r : rear_r;
        end
      end
      default: begin
      end
    endcase
    full_after = !empty_nxt && (idx_next(rear_nxt, cap_eff) == front_nxt);
  end

  assign sts.peek_hit = peek_hit;
  assign wdata        = DATA_WIDTH'({32'b0, value_r});
  assign rdata_s      = rdata;
  assign rdata_ext    = rdata_s;

  cd_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we && cmd.exec),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re && cmd.exec),
    .raddr (raddr),
    .rdata (rdata)
  );

  // latch the request word
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= op_t'(in_operation);
      value_r <= in_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r  <= '0;
      rear_r   <= '0;
      empty_r  <= 1'b1;
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= 1'b0;
      if (cmd.exec) begin
        front_r  <= front_nxt;
        rear_r   <= rear_nxt;
        empty_r  <= empty_nxt;
        strobe_r <= !peek_hit;
      end
      if (cmd.capture) begin
        strobe_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      ok_r       <= ok;
      data_r     <= '1;
      is_empty_r <= empty_nxt;
      is_full_r  <= full_after;
    end
    if (cmd.capture) begin
      data_r <= rdata_ext[31:0];
    end
  end

  assign out_strobe   = strobe_r;
  assign out_ok       = ok_r;
  assign out_data     = data_r;
  assign out_is_empty = is_empty_r;
  assign out_is_full  = is_full_r;

endmodule

FILE: sv/circular_deque_top.sv
// Push, pop and undefined codes: out_strobe is set as ST_EXEC ends; a peek first
// passes through ST_RDWAIT for the registered read of the ring memory.
// A request is taken only in ST_IDLE, so a new one waits until the last is through;
// busy is high from the accepting edge until the result is presented.
// Reset (rst_n low, synchronous): deque empty, indices zero, capacity 16;
// ring contents are not cleared. The receiver cannot stall the result.
module circular_deque_top import cd_pkg::*; #(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         in_operation,
  input  logic signed [31:0] in_value,
  output logic               out_strobe,
  output logic               out_ok,
  output logic signed [31:0] out_data,
  output logic               out_is_empty,
  output logic               out_is_full,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [2:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);

  cd_cmd_t          cmd;
  cd_sts_t          sts;
  logic [CAP_W-1:0] capacity_r;
  logic             cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                      && (cfg_paddr[2] == REG_CAPACITY);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAP_RESET;
    end else if (cfg_wr) begin
      capacity_r <= cfg_pwdata[CAP_W-1:0];
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == REG_CAPACITY) ? 32'(capacity_r) : '0;

  cd_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  cd_dpath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .capacity     (capacity_r),
    .in_operation (in_operation),
    .in_value     (in_value),
    .out_strobe   (out_strobe),
    .out_ok       (out_ok),
    .out_data     (out_data),
    .out_is_empty (out_is_empty),
    .out_is_full  (out_is_full)
  );

`ifndef SYNTHESIS
  a_empty_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !(out_is_empty && out_is_full))
    else $error("result flags both empty and full");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after accepting a word");

  a_strobe_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy))
    else $error("result strobe without a request in progress");

  a_fail_peek_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_ok) |-> (out_data == '1))
    else $error("failed request returned data other than -1");
`endif

endmodule
